@@ sv/pnrt_pkg.sv @@
// ----------------------------------------------------------------------------
// pnrt_pkg
// Shared types and constants for the packet number range tracker.
// ----------------------------------------------------------------------------
package pnrt_pkg;

    localparam int PN_W           = 62;
    localparam int TOT_W          = 63;
    localparam int HELD_W         = 6;
    localparam int MAX_RANGES_DEF = 32;

    // Result status codes
    localparam logic [1:0] ST_NEW  = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_TRIM = 2'd3;

    // Function codes
    localparam logic FN_INSERT = 1'b0;
    localparam logic FN_TRIM   = 1'b1;

    // One stored range, inclusive bounds
    typedef struct packed {
        logic [PN_W-1:0] last;
        logic [PN_W-1:0] first;
    } pnrt_entry_t;

endpackage

@@ sv/pnrt_store.sv @@
// ----------------------------------------------------------------------------
// pnrt_store
// Range table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pnrt_store #(
    parameter int MAX_RANGES = pnrt_pkg::MAX_RANGES_DEF
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(MAX_RANGES)-1:0] waddr,
    input  pnrt_pkg::pnrt_entry_t         wdata,
    input  logic [$clog2(MAX_RANGES)-1:0] raddr,
    output pnrt_pkg::pnrt_entry_t         rdata
);
    import pnrt_pkg::*;

    pnrt_entry_t mem [MAX_RANGES];
    pnrt_entry_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/pnrt_ctrl.sv @@
// ----------------------------------------------------------------------------
// pnrt_ctrl
// Sequencer: scans the table, merges/extends/inserts, shifts entries and
// trims to budget; holds fill and covered count plus the result register.
// ----------------------------------------------------------------------------
module pnrt_ctrl #(
    parameter int MAX_RANGES = pnrt_pkg::MAX_RANGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_func,
    input  logic [pnrt_pkg::PN_W-1:0]     in_pn,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    out_status,
    output logic [pnrt_pkg::TOT_W-1:0]    out_total,
    output logic [pnrt_pkg::HELD_W-1:0]   out_held,
    input  logic [pnrt_pkg::PN_W-1:0]     max_tracked,
    output logic                          mem_we,
    output logic [$clog2(MAX_RANGES)-1:0] mem_waddr,
    output pnrt_pkg::pnrt_entry_t         mem_wdata,
    output logic [$clog2(MAX_RANGES)-1:0] mem_raddr,
    input  pnrt_pkg::pnrt_entry_t         mem_rdata
);
    import pnrt_pkg::*;

    localparam int IDX_W  = $clog2(MAX_RANGES);
    localparam int FILL_W = $clog2(MAX_RANGES + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_RANGES);
    localparam logic [FILL_W-1:0] ONE      = FILL_W'(1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCAN_RD   = 4'd1;
    localparam logic [3:0] S_SCAN_CHK  = 4'd2;
    localparam logic [3:0] S_DECIDE    = 4'd3;
    localparam logic [3:0] S_COPY_RD   = 4'd4;
    localparam logic [3:0] S_COPY_WR   = 4'd5;
    localparam logic [3:0] S_PLACE     = 4'd6;
    localparam logic [3:0] S_TRIM_CHK  = 4'd7;
    localparam logic [3:0] S_TRIM_SPAN = 4'd8;
    localparam logic [3:0] S_TRIM_DO   = 4'd9;
    localparam logic [3:0] S_DONE      = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [TOT_W-1:0]  count_reg, count_next;
    logic              func_reg, func_next;
    logic [PN_W-1:0]   pn_reg, pn_next;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic [FILL_W-1:0] nx_reg, nx_next;
    logic              prev_ok_reg, prev_ok_next;
    logic              has_next_reg, has_next_next;
    pnrt_entry_t       prev_reg, prev_next;
    pnrt_entry_t       nxt_reg, nxt_next;
    logic              left_reg, left_next;
    logic [1:0]        status_reg, status_next;
    logic [TOT_W-1:0]  span_reg, span_next;
    logic [TOT_W-1:0]  excess_reg, excess_next;
    logic              ov_reg, ov_next;
    logic [1:0]        os_reg, os_next;
    logic [TOT_W-1:0]  ot_reg, ot_next;
    logic [HELD_W-1:0] oh_reg, oh_next;

    logic [FILL_W-1:0] waddr_w, raddr_w;
    logic [FILL_W-1:0] idx_p1, idx_m1;
    logic [TOT_W-1:0]  pn_p1, prev_last_p1;
    logic [63:0]       fill_ext;

    assign idx_p1       = idx_reg + ONE;
    assign idx_m1       = idx_reg - ONE;
    assign pn_p1        = {1'b0, pn_reg} + TOT_W'(1);
    assign prev_last_p1 = {1'b0, prev_reg.last} + TOT_W'(1);
    assign fill_ext     = 64'(fill_reg);

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = ov_reg;
    assign out_status = os_reg;
    assign out_total  = ot_reg;
    assign out_held   = oh_reg;
    assign mem_waddr  = waddr_w[IDX_W-1:0];
    assign mem_raddr  = raddr_w[IDX_W-1:0];

    // Next-state logic
    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        count_next    = count_reg;
        func_next     = func_reg;
        pn_next       = pn_reg;
        idx_next      = idx_reg;
        nx_next       = nx_reg;
        prev_ok_next  = prev_ok_reg;
        has_next_next = has_next_reg;
        prev_next     = prev_reg;
        nxt_next      = nxt_reg;
        left_next     = left_reg;
        status_next   = status_reg;
        span_next     = span_reg;
        excess_next   = excess_reg;
        ov_next       = ov_reg;
        os_next       = os_reg;
        ot_next       = ot_reg;
        oh_next       = oh_reg;
        mem_we        = 1'b0;
        waddr_w       = '0;
        mem_wdata     = '0;
        raddr_w       = '0;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next    = in_func;
                    pn_next      = in_pn;
                    idx_next     = '0;
                    prev_ok_next = 1'b0;
                    if (in_func == FN_TRIM)
                    begin
                        status_next = ST_TRIM;
                        state_next  = S_TRIM_CHK;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            // Walk ascending starts until one exceeds the number
            S_SCAN_RD:
            begin
                raddr_w = idx_reg;
                if (idx_reg == fill_reg)
                begin
                    nx_next       = idx_reg;
                    has_next_next = 1'b0;
                    state_next    = S_DECIDE;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (mem_rdata.first <= pn_reg)
                begin
                    prev_next    = mem_rdata;
                    prev_ok_next = 1'b1;
                    idx_next     = idx_p1;
                    state_next   = S_SCAN_RD;
                end
                else
                begin
                    nxt_next      = mem_rdata;
                    has_next_next = 1'b1;
                    nx_next       = idx_reg;
                    state_next    = S_DECIDE;
                end
            end
            // Choose duplicate, extend, merge, prepend, new range or full
            S_DECIDE:
            begin
                status_next = ST_NEW;
                state_next  = S_DONE;
                if (prev_ok_reg && (pn_reg <= prev_reg.last))
                begin
                    status_next = ST_DUP;
                end
                else if (prev_ok_reg && ({1'b0, pn_reg} == prev_last_p1))
                begin
                    count_next = count_reg + TOT_W'(1);
                    mem_we     = 1'b1;
                    waddr_w    = nx_reg - ONE;
                    if (has_next_reg && ({1'b0, nxt_reg.first} == pn_p1))
                    begin
                        mem_wdata.first = prev_reg.first;
                        mem_wdata.last  = nxt_reg.last;
                        idx_next        = nx_reg;
                        left_next       = 1'b1;
                        state_next      = S_COPY_RD;
                    end
                    else
                    begin
                        mem_wdata.first = prev_reg.first;
                        mem_wdata.last  = pn_reg;
                    end
                end
                else if (has_next_reg && ({1'b0, nxt_reg.first} == pn_p1))
                begin
                    count_next      = count_reg + TOT_W'(1);
                    mem_we          = 1'b1;
                    waddr_w         = nx_reg;
                    mem_wdata.first = pn_reg;
                    mem_wdata.last  = nxt_reg.last;
                end
                else if (fill_reg >= FILL_MAX)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    idx_next   = fill_reg;
                    left_next  = 1'b0;
                    state_next = S_COPY_RD;
                end
            end
            // Entry shift: each entry is read, then written
            S_COPY_RD:
            begin
                if (left_reg)
                begin
                    raddr_w = idx_p1;
                    if (idx_p1 >= fill_reg)
                    begin
                        fill_next  = fill_reg - ONE;
                        state_next = (func_reg == FN_TRIM) ? S_TRIM_CHK : S_DONE;
                    end
                    else
                    begin
                        state_next = S_COPY_WR;
                    end
                end
                else
                begin
                    raddr_w = idx_m1;
                    if (idx_reg <= nx_reg)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        state_next = S_COPY_WR;
                    end
                end
            end
            S_COPY_WR:
            begin
                mem_we     = 1'b1;
                waddr_w    = idx_reg;
                mem_wdata  = mem_rdata;
                idx_next   = left_reg ? idx_p1 : idx_m1;
                state_next = S_COPY_RD;
            end
            S_PLACE:
            begin
                mem_we          = 1'b1;
                waddr_w         = nx_reg;
                mem_wdata.first = pn_reg;
                mem_wdata.last  = pn_reg;
                fill_next       = fill_reg + ONE;
                count_next      = count_reg + TOT_W'(1);
                state_next      = S_DONE;
            end
            // Trim loop on the oldest range
            S_TRIM_CHK:
            begin
                raddr_w = '0;
                if ((fill_reg != '0) && (count_reg > {1'b0, max_tracked}))
                begin
                    state_next = S_TRIM_SPAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_TRIM_SPAN:
            begin
                prev_next   = mem_rdata;
                span_next   = {1'b0, mem_rdata.last} - {1'b0, mem_rdata.first}
                              + TOT_W'(1);
                excess_next = count_reg - {1'b0, max_tracked};
                state_next  = S_TRIM_DO;
            end
            S_TRIM_DO:
            begin
                if (span_reg <= excess_reg)
                begin
                    count_next = count_reg - span_reg;
                    idx_next   = '0;
                    left_next  = 1'b1;
                    state_next = S_COPY_RD;
                end
                else
                begin
                    mem_we          = 1'b1;
                    waddr_w         = '0;
                    mem_wdata.first = prev_reg.first + excess_reg[PN_W-1:0];
                    mem_wdata.last  = prev_reg.last;
                    count_next      = count_reg - excess_reg;
                    state_next      = S_TRIM_CHK;
                end
            end
            // Load the result register once it is free
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    os_next    = status_reg;
                    ot_next    = count_reg;
                    oh_next    = fill_ext[HELD_W-1:0];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        pn_reg       <= pn_next;
        idx_reg      <= idx_next;
        nx_reg       <= nx_next;
        prev_ok_reg  <= prev_ok_next;
        has_next_reg <= has_next_next;
        prev_reg     <= prev_next;
        nxt_reg      <= nxt_next;
        left_reg     <= left_next;
        status_reg   <= status_next;
        span_reg     <= span_next;
        excess_reg   <= excess_next;
        os_reg       <= os_next;
        ot_reg       <= ot_next;
        oh_reg       <= oh_next;
    end

endmodule

@@ sv/packet_number_range_tracker_top.sv @@
// Insert: the table is scanned from the lowest start until one exceeds the number;
// a new range shifts later entries up and is placed, a merge shifts entries down.
// Trim: the oldest range is read, then cut or dropped (shifting entries down), until
// the count is within max_tracked. One word in flight; s_tready returns with m_tvalid.
// Reset clears fill, covered count, result valid; max_tracked resets to 256.
// ----------------------------------------------------------------------------
// packet_number_range_tracker_top
// Sorted disjoint packet-number range table with covered count and trim.
// ----------------------------------------------------------------------------
module packet_number_range_tracker_top #(
    parameter int MAX_RANGES = pnrt_pkg::MAX_RANGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [61:0] packet_number
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [62:0] tracked_total, [68:63] ranges_held
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import pnrt_pkg::*;

    localparam logic [3:0] ADDR_MAX_TRACKED = 4'd0;

    logic [PN_W-1:0]   max_tracked_reg;
    logic [TOT_W-1:0]  total;
    logic [HELD_W-1:0] held;
    logic              mem_we;
    logic [$clog2(MAX_RANGES)-1:0] mem_waddr, mem_raddr;
    pnrt_entry_t       mem_wdata, mem_rdata;

    // Configuration register
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tracked_reg <= PN_W'(256);
        end
        else if (psel && penable && pwrite && (paddr == ADDR_MAX_TRACKED))
        begin
            max_tracked_reg <= pwdata[PN_W-1:0];
        end
    end
    assign prdata = (paddr == ADDR_MAX_TRACKED) ? {2'b00, max_tracked_reg} : 64'd0;

    assign m_tdata = {3'b000, held, total};

    pnrt_store #(.MAX_RANGES(MAX_RANGES)) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pnrt_ctrl #(.MAX_RANGES(MAX_RANGES)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_func     (s_tuser),
        .in_pn       (s_tdata[PN_W-1:0]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (m_tuser),
        .out_total   (total),
        .out_held    (held),
        .max_tracked (max_tracked_reg),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

endmodule
